// ===== rtl/pfa_pkg.sv =====
// Package: shared types, constants and lookup functions for the packed field array.
`default_nettype none

package pfa_pkg;

   localparam int STORE_WORDS  = 1024;
   localparam int ADDR_W       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int WORD_W       = 32;
   localparam int INDEX_W      = 15;
   localparam int WIDTH_W      = 6;
   localparam int COUNT_W      = 16;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int RECIP_W      = 21;
   localparam int RECIP_SHIFT  = 20;

   typedef enum logic [1:0] {
      CMD_GET   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BITS_PER_ENTRY = 4'd0,
      CSR_ENTRY_COUNT    = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [INDEX_W-1:0] index;
      logic [WORD_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic              index_error;
   } rsp_type;

   // Location of one entry: word number and range check.
   typedef struct packed {
      logic [INDEX_W-1:0] word_index;
      logic               err;
   } loc_type;

   // Item held between the read and the write-back.
   typedef struct packed {
      logic [1:0]         command;
      logic [INDEX_W-1:0] index;
      logic [WORD_W-1:0]  value;
      loc_type            loc;
   } op_type;

   // Clamp the configured width into 1..32.
   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] r;
      if (w == '0) begin
         r = WIDTH_W'(1);
      end else if (w > WIDTH_W'(WORD_W)) begin
         r = WIDTH_W'(WORD_W);
      end else begin
         r = w;
      end
      return r;
   endfunction

   // ceil(2^20 / entries_per_word), exact for every 15-bit index.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [WIDTH_W-1:0] w);
      logic [RECIP_W-1:0] r;
      unique case (w)
         6'd1:                                   r = 21'd32768;
         6'd2:                                   r = 21'd65536;
         6'd3:                                   r = 21'd104858;
         6'd4:                                   r = 21'd131072;
         6'd5:                                   r = 21'd174763;
         6'd6:                                   r = 21'd209716;
         6'd7, 6'd8:                             r = 21'd262144;
         6'd9, 6'd10:                            r = 21'd349526;
         6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16: r = 21'd524288;
         default:                                r = 21'd1048576;
      endcase
      return r;
   endfunction

   // Bits used per word: entries_per_word * width.
   function automatic logic [WIDTH_W-1:0] span_of(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] r;
      unique case (w)
         6'd1, 6'd2, 6'd4, 6'd8:                 r = 6'd32;
         6'd3, 6'd5, 6'd6, 6'd10:                r = 6'd30;
         6'd7:                                   r = 6'd28;
         6'd9:                                   r = 6'd27;
         6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16: r = {w[4:0], 1'b0};
         default:                                r = w;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pfa_word_ram.sv =====
// Single-port-read, single-port-write word memory with registered read data.
`default_nettype none

module pfa_word_ram import pfa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] mem_ff [STORE_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pfa_locate.sv =====
// Entry locator: word number by reciprocal multiply, plus the range check.
`default_nettype none

module pfa_locate import pfa_pkg::*; (
   input  wire logic [INDEX_W-1:0] index,
   input  wire logic [WIDTH_W-1:0] width,
   input  wire logic [COUNT_W-1:0] entry_count,
   output loc_type                 loc
);

   localparam int PROD_W = INDEX_W + RECIP_W;

   logic [PROD_W-1:0] quot_prod;
   logic [INDEX_W-1:0] word_index;

   always_comb begin
      quot_prod  = PROD_W'(index) * PROD_W'(recip_of(width));
      word_index = quot_prod[RECIP_SHIFT +: INDEX_W];
      loc.word_index = word_index;
      loc.err = (COUNT_W'(index) >= entry_count) ||
                (17'(word_index) >= 17'(STORE_WORDS));
   end

endmodule

`default_nettype wire

// ===== rtl/pfa_modify.sv =====
// Field merge: bit offset, mask, new word and returned entry value.
`default_nettype none

module pfa_modify import pfa_pkg::*; (
   input  wire op_type             op,
   input  wire logic [WIDTH_W-1:0] width,
   input  wire logic [WORD_W-1:0]  old_word,
   output logic                    wr_en,
   output logic      [WORD_W-1:0]  new_word,
   output rsp_type                 rsp
);

   logic [9:0]        prod_idx;
   logic [9:0]        prod_word;
   logic [4:0]        shift;
   logic [WORD_W-1:0] field_mask;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] word;

   always_comb begin
      // offset = idx*w - word*span, taken mod 32 since it is always below 32
      prod_idx   = 10'(op.index[4:0]) * 10'(width[4:0]);
      prod_word  = 10'(op.loc.word_index[4:0]) * 10'(span_of(width) & 6'h1f);
      shift      = prod_idx[4:0] - prod_word[4:0];
      field_mask = WORD_W'((33'd1 << width) - 33'd1);
      mask       = field_mask << shift;

      word  = old_word;
      wr_en = 1'b0;
      unique case (op.command)
         CMD_SET: begin
            word  = (old_word & ~mask) | ((op.value & field_mask) << shift);
            wr_en = !op.loc.err;
         end
         CMD_CLEAR: begin
            word  = old_word & ~mask;
            wr_en = !op.loc.err;
         end
         default: begin
            word = old_word;
         end
      endcase
      new_word = word;

      if (op.loc.err) begin
         rsp.read_value  = '0;
         rsp.index_error = 1'b1;
      end else begin
         rsp.read_value  = (word & mask) >> shift;
         rsp.index_error = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/packed_field_array_unit.sv =====
// Top level: packed bit-field array with get, set and clear by read-modify-write.
`default_nettype none

// For each item the accept cycle issues the word read, the next
// cycle merges the field and writes the word back, so busy is high for one
// cycle after each accept and a new item can start right after. The result
// appears with rsp_valid high for one cycle, the cycle after the write-back,
// and must be taken then. Rate is set by the single read port and the
// registered read of the word memory. After reset the block clears
// all 1024 words, one per cycle, and holds busy high until the last word is
// cleared; configuration writes are taken at any time.
module packed_field_array_unit import pfa_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_item,
   output logic                        rsp_valid,
   output rsp_type                     rsp_item,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STORE_WORDS - 1);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [WIDTH_W-1:0] bits_per_entry_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   op_type             op_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff;

   logic [WIDTH_W-1:0] width;
   logic               accept;
   loc_type            loc;
   logic [WORD_W-1:0]  rd_word;
   logic               mod_wr_en;
   logic [WORD_W-1:0]  mod_word;
   rsp_type            mod_rsp;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;

   assign width     = eff_width(bits_per_entry_ff);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_per_entry_ff <= WIDTH_W'(1);
         entry_count_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BITS_PER_ENTRY: bits_per_entry_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_ENTRY_COUNT:    entry_count_ff    <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pfa_locate u_locate (
      .index       (req_item.index),
      .width       (width),
      .entry_count (entry_count_ff),
      .loc         (loc)
   );

   pfa_modify u_modify (
      .op       (op_ff),
      .width    (width),
      .old_word (rd_word),
      .wr_en    (mod_wr_en),
      .new_word (mod_word),
      .rsp      (mod_rsp)
   );

   pfa_word_ram u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (loc.word_index[ADDR_W-1:0]),
      .rd_data (rd_word),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff.command <= req_item.command;
         op_ff.index   <= req_item.index;
         op_ff.value   <= req_item.value;
         op_ff.loc     <= loc;
      end
      if (state_ff == ST_MODIFY) begin
         rsp_item_ff <= mod_rsp;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = 1'b0;
      busy         = 1'b1;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            ram_wr_en    = mod_wr_en;
            ram_wr_addr  = op_ff.loc.word_index[ADDR_W-1:0];
            ram_wr_data  = mod_word;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_rsp_follows_modify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_MODIFY))
      else $error("result strobe without a write-back cycle");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.index_error |-> rsp_item.read_value == '0)
      else $error("flagged item returned a nonzero value");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy ##1 rsp_valid)
      else $error("accepted item did not complete in two cycles");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_CLEAR || state_ff == ST_MODIFY)
      else $error("word store written outside clear or write-back");

endmodule

`default_nettype wire

// ===== dv/packed_field_array_unit_test.sv =====
// Testbench for the packed field array: directed and random get/set/clear items vs a predictor.
`timescale 1ns / 100ps

module packed_field_array_unit_test;
   import pfa_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;   // acts as get
   localparam int CYCLE_LIMIT = 100000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 115;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_item = '0;
   logic                   rsp_valid;
   rsp_type                rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Mirror of the block: word store and register values.
   logic [WORD_W-1:0]  word_image [STORE_WORDS] = '{default: '0};
   logic [WIDTH_W-1:0] width_cfg = 6'd1;
   logic [COUNT_W-1:0] count_cfg = '0;

   rsp_type expected_rsp [$];
   rsp_type head_rsp;
   bit      gaps_on = 1'b1;
   int      mismatches = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      flagged_count = 0;
   int      settings_count = 0;
   int      cycle_count = 0;

   packed_field_array_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned eff_bits(input logic [WIDTH_W-1:0] w);
      if (w == '0) return 1;
      if (w > WIDTH_W'(WORD_W)) return WORD_W;
      return w;
   endfunction

   // Masked read-modify-write of one entry against the mirrored store.
   function automatic rsp_type predict_access(input logic [1:0] cmd,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [WORD_W-1:0] val);
      int unsigned w, per_word, word_no, shift;
      logic [63:0] field_mask;
      logic [WORD_W-1:0] mask, word;
      rsp_type r;
      w = eff_bits(width_cfg);
      per_word = WORD_W / w;
      word_no = idx / per_word;
      shift = (idx - word_no * per_word) * w;
      field_mask = (64'd1 << w) - 64'd1;
      mask = WORD_W'(field_mask << shift);
      r.read_value = '0;
      r.index_error = 1'b1;
      if (idx < count_cfg && word_no < STORE_WORDS) begin
         word = word_image[word_no];
         if (cmd == CMD_SET) begin
            word = (word & ~mask) | WORD_W'((64'(val) & field_mask) << shift);
            word_image[word_no] = word;
         end else if (cmd == CMD_CLEAR) begin
            word = word & ~mask;
            word_image[word_no] = word;
         end
         r.read_value = (word & mask) >> shift;
         r.index_error = 1'b0;
      end else begin
         flagged_count++;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                  input logic [WORD_W-1:0] got);
      mismatches++;
      if (mismatches <= 20)
         $display("%0t: mismatch on %s, expected %h got %h", $time, what, want, got);
   endtask

   // Send one item; start stays high on return so the next item can follow at once.
   task automatic send_access(input logic [1:0] cmd, input logic [INDEX_W-1:0] idx,
                              input logic [WORD_W-1:0] val);
      if (gaps_on && $urandom_range(0, 99) < 18) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= '{command: cmd, index: idx, value: val};
      do @(posedge clock); while (busy);
      expected_rsp.push_back(predict_access(cmd, idx, val));
      sent_count++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leave csr_valid high on return; the caller drops it after the last write.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      if (gaps_on && $urandom_range(0, 99) < 18) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BITS_PER_ENTRY)
         width_cfg = data[WIDTH_W-1:0];
      else
         count_cfg = data;
   endtask

   task automatic configure(input logic [WIDTH_W-1:0] w, input logic [COUNT_W-1:0] cnt,
                            input logic [CSR_DATA_W-WIDTH_W-1:0] pad);
      wait_idle();
      write_register(CSR_BITS_PER_ENTRY, {pad, w});
      write_register(CSR_ENTRY_COUNT, cnt);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   task automatic test_reset_clear();
      configure(6'd1, 16'd32768, '0);
      send_access(CMD_GET, 15'd0, 32'h0);
      send_access(CMD_GET, 15'd32767, 32'hFFFF_FFFF);
   endtask

   task automatic test_narrow_entries();
      send_access(CMD_SET, 15'd32767, 32'hFFFF_FFFF);
      send_access(CMD_GET, 15'd32766, 32'h0);
      send_access(CMD_SET, 15'd0, 32'h0000_0002);     // too wide: stored bit is 0
      send_access(CMD_CLEAR, 15'd32767, 32'hFFFF_FFFF);
      send_access(CMD_UNUSED, 15'd32767, 32'h0);
   endtask

   task automatic test_wide_entries();
      configure(6'd32, 16'hFFFF, '0);
      send_access(CMD_SET, 15'd1023, 32'hFFFF_FFFF);
      send_access(CMD_UNUSED, 15'd1023, 32'h0);
      send_access(CMD_SET, 15'd1024, 32'h1234_5678);  // word beyond the store
      send_access(CMD_SET, 15'd0, 32'hA5A5_5A5A);
      send_access(CMD_CLEAR, 15'd0, 32'h0);
   endtask

   task automatic test_width_clamp();
      configure(6'd0, 16'd16, '0);                     // zero width acts as one bit
      send_access(CMD_SET, 15'd15, 32'h0000_0003);
      send_access(CMD_GET, 15'd14, 32'h0);
      configure(6'd63, 16'd16, '1);                    // above 32 acts as 32
      send_access(CMD_UNUSED, 15'd0, 32'h0);
      send_access(CMD_GET, 15'd16, 32'h0);
   endtask

   task automatic test_index_range();
      configure(6'd3, 16'd0, '0);
      send_access(CMD_GET, 15'd0, 32'h0);
      configure(6'd3, 16'd100, '0);
      send_access(CMD_SET, 15'd99, 32'hFFFF_FFFE);
      send_access(CMD_SET, 15'd100, 32'h7);
      send_access(CMD_GET, 15'd99, 32'h0);
   endtask

   // Each phase hammers a small group of neighboring entries plus spread and out-of-range items.
   task automatic test_random_accesses();
      logic [WIDTH_W-1:0] widths [PHASES] = '{6'd1, 6'd3, 6'd5, 6'd7, 6'd9,
                                              6'd12, 6'd17, 6'd32, 6'd0, 6'd63};
      logic [COUNT_W-1:0] cnt;
      logic [1:0] cmd;
      logic [WORD_W-1:0] val;
      int unsigned lim, base, idx, pick;
      for (int p = 0; p < PHASES; p++) begin
         if (p % 3 == 0)
            cnt = '1;
         else if (p == 4)
            cnt = 16'd32768;
         else
            cnt = $urandom_range(64, 32768);
         gaps_on = (p != 5);
         configure(widths[p], cnt, 10'($urandom()));
         lim = STORE_WORDS * (WORD_W / eff_bits(widths[p]));
         if (cnt < lim) lim = cnt;
         base = $urandom_range(0, lim - 8);
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) cmd = CMD_SET;
            else if (pick < 75) cmd = CMD_GET;
            else if (pick < 90) cmd = CMD_CLEAR;
            else cmd = CMD_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 50) idx = base + $urandom_range(0, 7);
            else if (pick < 85) idx = $urandom_range(0, lim - 1);
            else idx = $urandom_range(0, 32767);
            pick = $urandom_range(0, 99);
            if (pick < 10) val = '1;
            else if (pick < 20) val = $urandom_range(0, 3);
            else val = $urandom();
            send_access(cmd, INDEX_W'(idx), val);
         end
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_item.read_value);
         end else begin
            head_rsp = expected_rsp.pop_front();
            checked_count++;
            if (rsp_item.read_value !== head_rsp.read_value)
               report_mismatch("read_value", head_rsp.read_value, rsp_item.read_value);
            if (rsp_item.index_error !== head_rsp.index_error)
               report_mismatch("index_error", head_rsp.index_error, rsp_item.index_error);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_clear();
      test_narrow_entries();
      test_wide_entries();
      test_width_clamp();
      test_index_range();
      test_random_accesses();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("%0d items sent, %0d results checked, %0d of them index errors",
               sent_count, checked_count, flagged_count);
      $display("%0d register settings, widths 0..63 and counts 0..65535", settings_count);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
